/* hw/rtl/mpc_pkg.sv */
package mpc_pkg;

    localparam int MOIST_W  = 10;
    localparam int COUNT_W  = 16;
    localparam int SAMPLE_W = 8;
    localparam int PADDR_W  = 5;

    localparam logic [MOIST_W-1:0]  MIN_MOIST_RST  = 10'd300;
    localparam logic [MOIST_W-1:0]  MAX_MOIST_RST  = 10'd800;
    localparam logic [COUNT_W-1:0]  AUTO_DUR_RST   = 16'd10;
    localparam logic [COUNT_W-1:0]  MANUAL_DUR_RST = 16'd5;
    localparam logic [SAMPLE_W-1:0] INTERVAL_RST   = 8'd2;

    typedef enum logic [2:0] {
        REG_MIN_MOISTURE    = 3'd0,
        REG_MAX_MOISTURE    = 3'd1,
        REG_AUTO_DURATION   = 3'd2,
        REG_MANUAL_DURATION = 3'd3,
        REG_SAMPLE_INTERVAL = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               mode_press;
        logic               water_press;
        logic [MOIST_W-1:0] moisture_now;
    } in_t;

    typedef struct packed {
        logic pump_on;
        logic led_state;
        logic manual_mode;
    } out_t;

    typedef struct packed {
        logic [MOIST_W-1:0]  min_moisture;
        logic [MOIST_W-1:0]  max_moisture;
        logic [COUNT_W-1:0]  auto_duration;
        logic [COUNT_W-1:0]  manual_duration;
        logic [SAMPLE_W-1:0] sample_interval;
    } cfg_t;

    // result of one tick handed to the output buffer
    typedef struct packed {
        logic load;
        out_t data;
    } res_t;

endpackage

/* hw/rtl/mpc_cfg.sv */
module mpc_cfg
    import mpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_moisture    <= MIN_MOIST_RST;
            cfg_reg.max_moisture    <= MAX_MOIST_RST;
            cfg_reg.auto_duration   <= AUTO_DUR_RST;
            cfg_reg.manual_duration <= MANUAL_DUR_RST;
            cfg_reg.sample_interval <= INTERVAL_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIN_MOISTURE:    cfg_reg.min_moisture    <= pwdata[MOIST_W-1:0];
                REG_MAX_MOISTURE:    cfg_reg.max_moisture    <= pwdata[MOIST_W-1:0];
                REG_AUTO_DURATION:   cfg_reg.auto_duration   <= pwdata[COUNT_W-1:0];
                REG_MANUAL_DURATION: cfg_reg.manual_duration <= pwdata[COUNT_W-1:0];
                REG_SAMPLE_INTERVAL: cfg_reg.sample_interval <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_MIN_MOISTURE:    prdata = {22'd0, cfg_reg.min_moisture};
            REG_MAX_MOISTURE:    prdata = {22'd0, cfg_reg.max_moisture};
            REG_AUTO_DURATION:   prdata = {16'd0, cfg_reg.auto_duration};
            REG_MANUAL_DURATION: prdata = {16'd0, cfg_reg.manual_duration};
            REG_SAMPLE_INTERVAL: prdata = {24'd0, cfg_reg.sample_interval};
            default:             prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/mpc_core.sv */
module mpc_core
    import mpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  in_t  in_data,
    input  cfg_t cfg,
    output res_t res
);

    logic                mode_reg, mode_next;
    logic                pump_reg, pump_next;
    logic                led_reg, led_next;
    logic [COUNT_W-1:0]  wcount_reg, wcount_next;
    logic [SAMPLE_W-1:0] scount_reg, scount_next;
    logic [MOIST_W-1:0]  moist_reg, moist_next;
    logic [SAMPLE_W:0]   scount_inc;

    always_comb
    begin
        mode_next   = mode_reg ^ in_data.mode_press;
        pump_next   = pump_reg;
        led_next    = led_reg;
        wcount_next = wcount_reg;
        moist_next  = moist_reg;

        // entering manual forces the pump off, LED untouched
        if (in_data.mode_press && !mode_reg)
            pump_next = 1'b0;
        if (mode_next && in_data.water_press && !pump_next)
        begin
            pump_next   = 1'b1;
            wcount_next = '0;
            led_next    = 1'b1;
        end

        // count can reach 2^SAMPLE_W, which always latches
        scount_inc = {1'b0, scount_reg} + 1'b1;
        if (scount_inc >= {1'b0, cfg.sample_interval})
        begin
            moist_next  = in_data.moisture_now;
            scount_next = '0;
        end
        else
            scount_next = scount_inc[SAMPLE_W-1:0];

        if (!mode_next)
        begin
            if (!pump_next)
            begin
                led_next = 1'b0;
                if (moist_next < cfg.min_moisture)
                begin
                    pump_next   = 1'b1;
                    led_next    = 1'b1;
                    wcount_next = '0;
                end
            end
            else
            begin
                if (wcount_next != '1)
                    wcount_next = wcount_next + 1'b1;
                if (moist_next > cfg.max_moisture || wcount_next >= cfg.auto_duration)
                begin
                    pump_next = 1'b0;
                    led_next  = 1'b0;
                end
            end
        end
        else if (pump_next)
        begin
            if (wcount_next != '1)
                wcount_next = wcount_next + 1'b1;
            if (wcount_next >= cfg.manual_duration)
            begin
                pump_next = 1'b0;
                led_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            pump_reg   <= 1'b0;
            led_reg    <= 1'b0;
            wcount_reg <= '0;
            scount_reg <= '0;
            moist_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pump_reg   <= pump_next;
            led_reg    <= led_next;
            wcount_reg <= wcount_next;
            scount_reg <= scount_next;
            moist_reg  <= moist_next;
        end
    end

    assign res.load             = accept;
    assign res.data.pump_on     = pump_next;
    assign res.data.led_state   = led_next;
    assign res.data.manual_mode = mode_next;

endmodule

/* hw/rtl/mpc_out_buf.sv */
module mpc_out_buf
    import mpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  res_t res,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic out_valid_reg;
    out_t out_data_reg;
    logic skid_valid_reg;
    out_t skid_data_reg;
    logic take;

    assign take      = out_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            // skid holds the older result, so it goes out first
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= res.load;
        end
        else if (res.load)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (res.load)
                out_data_reg <= res.data;
        end
        else if (res.load)
            skid_data_reg <= res.data;
    end

endmodule

/* hw/rtl/moisture_pump_controller.sv */
// Soil-moisture watering controller.
// Input channel (in_valid / in_stall / in_data): one transfer per control
// tick, carrying the mode and water button states and a moisture sample.
// Output channel (out_valid / out_stall / out_data): one transfer per tick
// with pump drive, LED state and current mode after that tick.
// Configuration: APB-style port, registers at byte address 4*index
// (thresholds, auto and manual pump durations, sample interval); write only
// while no tick is in flight.
// Result: each tick's result is registered in the output buffer.
// Throughput: one tick per cycle while in_stall is low; the state update is
// a single pass of compares and counter steps from the accepted input to
// the result register. Stall: a two-entry output buffer (result register
// plus skid) takes one more input transfer after out_stall rises; in_stall
// is high while the skid entry is occupied.
// Reset: thresholds, durations and sample interval return to defaults,
// mode goes to auto, pump off, LED normal, counters and latched moisture
// cleared, both buffer entries emptied.
module moisture_pump_controller
    import mpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_t                in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_t               out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t cfg;
    res_t res;
    logic accept;
    logic full;

    assign in_stall = full;
    assign accept   = in_valid & ~full;

    mpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .cfg     (cfg),
        .res     (res)
    );

    mpc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* test/tb_moisture_pump_controller.sv */
module tb_moisture_pump_controller
    import mpc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_DIR          = 20;
    localparam int IDLE_PCT       = 19;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_t                in_data  = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_t               out_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    moisture_pump_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    // controller state as predicted
    cfg_t                cfg_m;
    logic                mode_m;
    logic                pump_m;
    logic                led_m;
    logic [COUNT_W-1:0]  water_cnt;
    logic [SAMPLE_W-1:0] sample_cnt;
    logic [MOIST_W-1:0]  moist_latched;

    out_t tick_q[$];
    out_t want_res;
    int   err_cnt      = 0;
    int   stuck_cycles = 0;
    logic quiet        = 1'b0;

    typedef struct packed {
        in_t  tick;
        logic typed;
        out_t want;
    } dir_row_t;

    // rows with typed results hold values that follow directly from reset
    dir_row_t dir_tab [N_DIR] = '{
        '{'{1'b0, 1'b0, 10'd500},  1'b1, '{1'b1, 1'b1, 1'b0}},
        '{'{1'b0, 1'b1, 10'd500},  1'b0, '0},
        '{'{1'b1, 1'b0, 10'd1000}, 1'b1, '{1'b0, 1'b1, 1'b1}},
        '{'{1'b0, 1'b1, 10'd0},    1'b0, '0},
        '{'{1'b0, 1'b1, 10'd1023}, 1'b0, '0},
        '{'{1'b0, 1'b0, 10'd1023}, 1'b0, '0},
        '{'{1'b1, 1'b0, 10'd1023}, 1'b0, '0},
        '{'{1'b0, 1'b0, 10'd0},    1'b0, '0},
        '{'{1'b0, 1'b0, 10'd0},    1'b0, '0},
        '{'{1'b0, 1'b0, 10'd299},  1'b0, '0},
        '{'{1'b0, 1'b0, 10'd300},  1'b0, '0},
        '{'{1'b0, 1'b0, 10'd301},  1'b0, '0},
        '{'{1'b0, 1'b0, 10'd800},  1'b0, '0},
        '{'{1'b0, 1'b0, 10'd801},  1'b0, '0},
        '{'{1'b0, 1'b0, 10'd801},  1'b0, '0},
        '{'{1'b1, 1'b1, 10'h2AA},  1'b0, '0},
        '{'{1'b1, 1'b1, 10'h155},  1'b0, '0},
        '{'{1'b0, 1'b1, 10'd1000}, 1'b0, '0},
        '{'{1'b1, 1'b0, 10'd0},    1'b0, '0},
        '{'{1'b0, 1'b0, 10'd1000}, 1'b0, '0}
    };

    task automatic predict_tick(input in_t t, output out_t r);
        logic [SAMPLE_W:0] sc;
        if (t.mode_press)
        begin
            if (!mode_m)
            begin
                mode_m = 1'b1;
                pump_m = 1'b0;
            end
            else
                mode_m = 1'b0;
        end
        if (mode_m && t.water_press && !pump_m)
        begin
            pump_m    = 1'b1;
            water_cnt = '0;
            led_m     = 1'b1;
        end
        // one extra bit so a count of 255 still latches
        sc = {1'b0, sample_cnt} + 1'b1;
        if (sc >= {1'b0, cfg_m.sample_interval})
        begin
            moist_latched = t.moisture_now;
            sc = '0;
        end
        sample_cnt = sc[SAMPLE_W-1:0];
        if (!mode_m)
        begin
            if (!pump_m)
            begin
                led_m = 1'b0;
                if (moist_latched < cfg_m.min_moisture)
                begin
                    pump_m    = 1'b1;
                    led_m     = 1'b1;
                    water_cnt = '0;
                end
            end
            else
            begin
                if (water_cnt != '1)
                    water_cnt = water_cnt + 1'b1;
                if (moist_latched > cfg_m.max_moisture || water_cnt >= cfg_m.auto_duration)
                begin
                    pump_m = 1'b0;
                    led_m  = 1'b0;
                end
            end
        end
        else if (pump_m)
        begin
            if (water_cnt != '1)
                water_cnt = water_cnt + 1'b1;
            if (water_cnt >= cfg_m.manual_duration)
            begin
                pump_m = 1'b0;
                led_m  = 1'b0;
            end
        end
        r.pump_on     = pump_m;
        r.led_state   = led_m;
        r.manual_mode = mode_m;
    endtask

    task automatic send_tick(input in_t t, input logic typed, input out_t want);
        out_t pred;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_tick(t, pred);
        tick_q.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tick_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_MOISTURE:    cfg_m.min_moisture    = val[MOIST_W-1:0];
            REG_MAX_MOISTURE:    cfg_m.max_moisture    = val[MOIST_W-1:0];
            REG_AUTO_DURATION:   cfg_m.auto_duration   = val[COUNT_W-1:0];
            REG_MANUAL_DURATION: cfg_m.manual_duration = val[COUNT_W-1:0];
            REG_SAMPLE_INTERVAL: cfg_m.sample_interval = val[SAMPLE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        drain();
        repeat (2) @(posedge clk);
        write_reg(REG_MIN_MOISTURE,    32'(c.min_moisture));
        write_reg(REG_MAX_MOISTURE,    32'(c.max_moisture));
        write_reg(REG_AUTO_DURATION,   32'(c.auto_duration));
        write_reg(REG_MANUAL_DURATION, 32'(c.manual_duration));
        write_reg(REG_SAMPLE_INTERVAL, 32'(c.sample_interval));
    endtask

    function automatic in_t rand_tick();
        in_t t;
        int  pick;
        t.mode_press  = ($urandom_range(99) < 8);
        t.water_press = ($urandom_range(99) < 25);
        pick = $urandom_range(9);
        if (pick == 0)
            t.moisture_now = '0;
        else if (pick == 1)
            t.moisture_now = '1;
        else if (pick == 2)
            t.moisture_now = 10'd1000;
        else
            t.moisture_now = MOIST_W'($urandom_range(1023));
        return t;
    endfunction

    function automatic logic [COUNT_W-1:0] rand_duration();
        case ($urandom_range(9))
            0:       return '0;
            1:       return COUNT_W'(1);
            2:       return COUNT_W'($urandom_range(300));
            default: return COUNT_W'($urandom_range(30, 2));
        endcase
    endfunction

    function automatic cfg_t rand_config();
        cfg_t c;
        c.min_moisture    = MOIST_W'($urandom_range(1000));
        c.max_moisture    = MOIST_W'($urandom_range(1000));
        c.auto_duration   = rand_duration();
        c.manual_duration = rand_duration();
        c.sample_interval = ($urandom_range(9) < 6) ? SAMPLE_W'($urandom_range(4))
                                                    : SAMPLE_W'($urandom_range(255));
        return c;
    endfunction

    task automatic run_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_tick(rand_tick(), 1'b0, '0);
            // let the pipe run dry now and then
            if (i % 150 == 149)
                drain();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (tick_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result transfer: got pump_on=%0b led=%0b manual=%0b",
                             out_data.pump_on, out_data.led_state, out_data.manual_mode);
            end
            else
            begin
                want_res = tick_q.pop_front();
                if (out_data.pump_on !== want_res.pump_on
                    || out_data.led_state !== want_res.led_state
                    || out_data.manual_mode !== want_res.manual_mode)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: want pump_on=%0b led=%0b manual=%0b, got %0b %0b %0b",
                                 want_res.pump_on, want_res.led_state, want_res.manual_mode,
                                 out_data.pump_on, out_data.led_state,
                                 out_data.manual_mode);
                end
            end
        end
    end

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        cfg_m         = '{MIN_MOIST_RST, MAX_MOIST_RST, AUTO_DUR_RST, MANUAL_DUR_RST,
                          INTERVAL_RST};
        mode_m        = 1'b0;
        pump_m        = 1'b0;
        led_m         = 1'b0;
        water_cnt     = '0;
        sample_cnt    = '0;
        moist_latched = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_tick(dir_tab[i].tick, dir_tab[i].typed, dir_tab[i].want);

        // zero durations and zero interval
        set_config('{10'd0, 10'd1000, 16'd0, 16'd0, 8'd0});
        run_ticks(30);
        set_config('{10'd1000, 10'd0, 16'd1, 16'd1, 8'd1});
        run_ticks(30);
        set_config('{10'd1000, 10'd1000, 16'hFFFF, 16'hFFFF, 8'd255});
        run_ticks(300);
        // interval dropped below the running count
        set_config('{10'd1000, 10'd1000, 16'hFFFF, 16'hFFFF, 8'd3});
        run_ticks(20);

        // one long manual watering, run to its end
        set_config('{10'd300, 10'd800, 16'd10, 16'd140, 8'd2});
        if (mode_m)
            send_tick('{1'b1, 1'b0, 10'd500}, 1'b0, '0);
        send_tick('{1'b1, 1'b0, 10'd500}, 1'b0, '0);
        send_tick('{1'b0, 1'b1, 10'd500}, 1'b0, '0);
        for (int i = 0; i < 150; i++)
            send_tick('{1'b0, 1'b0, MOIST_W'($urandom_range(1023))}, 1'b0, '0);

        set_config('{MIN_MOIST_RST, MAX_MOIST_RST, AUTO_DUR_RST, MANUAL_DUR_RST,
                     INTERVAL_RST});
        run_ticks(100);
        for (int p = 0; p < 5; p++)
        begin
            set_config(rand_config());
            quiet = (p == 3);
            run_ticks(100);
        end
        quiet = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (tick_q.size() != 0)
            err_cnt++;
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
